// ===== rtl/core/fcts_pkg.sv =====
// Shared types and constants for the function call trace stack.
// Used by fcts_table and function_call_trace_stack_top; no dependencies.
package fcts_pkg;

  localparam int TABLE_ENTRIES_DEF = 512;
  localparam int STACK_DEPTH_DEF   = 32;

  localparam int KEY_W   = 9;
  localparam int DEPTH_W = 16;
  localparam int ADDR_W  = 32;
  localparam int CNT_W   = 10;

  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 96;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [31:0] RET_WORD = 32'h0000_8067;

  localparam logic REG_TRACE_EN = 1'b0;
  localparam logic REG_FUNC_CNT = 1'b1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_TRACE = 1'b1
  } op_e;

  typedef enum logic {
    EV_CALL   = 1'b0,
    EV_RETURN = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIND,
    ST_RET_ONE,
    ST_POP_RD,
    ST_POP_EMIT,
    ST_CALL
  } state_e;

  typedef struct packed {
    logic start;
    logic ret_mode;
  } scan_req_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [KEY_W-1:0] key;
  } scan_res_t;

  typedef struct packed {
    kind_e              kind;
    logic [KEY_W-1:0]   idx;
    logic [DEPTH_W-1:0] depth;
    logic [ADDR_W-1:0]  pc;
    logic [ADDR_W-1:0]  target;
    logic               last;
  } event_t;

endpackage

// ===== rtl/core/fcts_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fcts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/fcts_table.sv =====
// Function table memory (start, size) and a one-entry-per-cycle search unit.
// Depends on fcts_pkg and fcts_ram.
module fcts_table #(
  parameter int TABLE_ENTRIES = fcts_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr_i,
  input  logic [fcts_pkg::ADDR_W-1:0]      wr_start_i,
  input  logic [fcts_pkg::ADDR_W-1:0]      wr_size_i,
  input  fcts_pkg::scan_req_t              req_i,
  input  logic [fcts_pkg::CNT_W-1:0]       count_i,
  input  logic [fcts_pkg::ADDR_W-1:0]      pc_i,
  input  logic [fcts_pkg::ADDR_W-1:0]      target_i,
  output fcts_pkg::scan_res_t              res_o
);
  import fcts_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int LW = (CW > CNT_W) ? CW : CNT_W;

  logic              busy_q, busy_d;
  logic              mode_q, mode_d;
  logic              vld_q, vld_d;
  logic [CW-1:0]     addr_q, addr_d;
  logic [CW-1:0]     lim_q, lim_d;
  logic [AW-1:0]     cmp_q, cmp_d;
  logic [CW-1:0]     lim;
  logic              issue;
  logic              match;
  logic [2*ADDR_W-1:0] rdata;
  logic [ADDR_W-1:0] lo, hi;

  fcts_ram #(
    .WIDTH(2 * ADDR_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i ({wr_size_i, wr_start_i}),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign lim   = (LW'(count_i) > LW'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES) : CW'(count_i);
  assign lo    = rdata[ADDR_W-1:0];
  assign hi    = lo + rdata[2*ADDR_W-1:ADDR_W];
  assign issue = busy_q && (addr_q < lim_q);
  assign match = vld_q && (mode_q ? ((pc_i >= lo) && (pc_i <= hi)) : (target_i == lo));

  assign res_o.done = match || (busy_q && !issue && !vld_q);
  assign res_o.hit  = match;
  assign res_o.key  = KEY_W'(cmp_q);

  always_comb begin
    busy_d = busy_q;
    mode_d = mode_q;
    lim_d  = lim_q;
    addr_d = addr_q;
    cmp_d  = cmp_q;
    vld_d  = issue;
    if (issue) begin
      addr_d = addr_q + 1'b1;
      cmp_d  = addr_q[AW-1:0];
    end
    if (res_o.done) begin
      busy_d = 1'b0;
      vld_d  = 1'b0;
    end
    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.ret_mode;
      lim_d  = lim;
      addr_d = '0;
      vld_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    lim_q  <= lim_d;
    addr_q <= addr_d;
    cmp_q  <= cmp_d;
  end

endmodule

// ===== rtl/core/function_call_trace_stack_top.sv =====
// Top level of the function call trace stack: stream ports, APB registers,
// control sequencer, call stack memory. Depends on fcts_pkg, fcts_ram, fcts_table.
//
// A load transaction writes one function table entry when its index is below
// TABLE_ENTRIES. A trace transaction searches the function table one entry per
// cycle through its single read port, up to min(function_count, TABLE_ENTRIES)
// entries, and searches it twice when a return word lies in no function. A return
// then searches the call stack memory top down, one entry per cycle, and pops each
// entry through ST_POP_RD and ST_POP_EMIT; a call pushes its entry in ST_CALL. No
// clearing pass follows reset. The input side accepts the next transaction while
// the last event still waits in the output register.
module function_call_trace_stack_top #(
  parameter int TABLE_ENTRIES = fcts_pkg::TABLE_ENTRIES_DEF,
  parameter int STACK_DEPTH   = fcts_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fcts_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fcts_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fcts_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // entry_index, entry_start, entry_size, jump_target, instr_pc, instr_word
  input  logic [fcts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // function_index, call_depth, event_pc, event_target
  output logic [fcts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // event_kind
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import fcts_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int PA = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int SW = FW + 1;

  function automatic logic [PA-1:0] phys(input logic [PA-1:0] base, input logic [FW-1:0] p);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(p);
    if (sum >= SW'(STACK_DEPTH)) begin
      sum = sum - SW'(STACK_DEPTH);
    end
    return PA'(sum);
  endfunction

  state_e             state_q, state_d;
  logic               te_q;
  logic [CNT_W-1:0]   fc_q;
  logic [ADDR_W-1:0]  pc_q, pc_d, tgt_q, tgt_d;
  logic               ret_q, ret_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [PA-1:0]      base_q, base_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [PA-1:0]      pos_q, pos_d;
  logic [FW-1:0]      scnt_q, scnt_d;
  logic               svld_q, svld_d;
  logic [PA-1:0]      spos_q, spos_d;
  logic               out_vld_q;
  event_t             out_q, ev;
  logic               out_load;
  logic               out_free;

  logic               in_acc;
  op_e                in_op;
  logic [KEY_W-1:0]   in_idx;
  logic [ADDR_W-1:0]  in_start, in_size, in_tgt, in_pc, in_word;
  logic               tbl_we;
  scan_req_t          scan_req;
  scan_res_t          scan_res;
  logic               stk_we;
  logic [PA-1:0]      stk_waddr, stk_raddr;
  logic [KEY_W-1:0]   stk_rdata;
  logic [FW-1:0]      wpos;
  logic               pop_last;
  logic               cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_TRACE_EN: prdata = APB_DATA_W'(te_q);
      default:      prdata = APB_DATA_W'(fc_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      te_q <= 1'b1;
      fc_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TRACE_EN: te_q <= pwdata[0];
        default:      fc_q <= pwdata[CNT_W-1:0];
      endcase
    end
  end

  // Input unpacking
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_op    = op_e'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[8:0];
  assign in_start = s_axis_tdata[40:9];
  assign in_size  = s_axis_tdata[72:41];
  assign in_tgt   = s_axis_tdata[104:73];
  assign in_pc    = s_axis_tdata[136:105];
  assign in_word  = s_axis_tdata[168:137];
  assign tbl_we   = in_acc && (in_op == OP_LOAD) && (32'(in_idx) < TABLE_ENTRIES);

  assign s_axis_tready = (state_q == ST_IDLE);

  fcts_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (tbl_we),
    .wr_addr_i  (AW'(in_idx)),
    .wr_start_i (in_start),
    .wr_size_i  (in_size),
    .req_i      (scan_req),
    .count_i    (fc_q),
    .pc_i       (pc_q),
    .target_i   (tgt_q),
    .res_o      (scan_res)
  );

  fcts_ram #(
    .WIDTH(KEY_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (key_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign out_free = !out_vld_q || m_axis_tready;
  assign wpos     = (fill_q == FW'(STACK_DEPTH)) ? '0 : fill_q;
  assign pop_last = ((fill_q - 1'b1) == FW'(pos_q));

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    tgt_d     = tgt_q;
    ret_d     = ret_q;
    key_d     = key_q;
    fill_d    = fill_q;
    base_d    = base_q;
    depth_d   = depth_q;
    pos_d     = pos_q;
    scnt_d    = scnt_q;
    svld_d    = 1'b0;
    spos_d    = spos_q;
    scan_req  = '0;
    stk_we    = 1'b0;
    stk_waddr = phys(base_q, wpos);
    stk_raddr = phys(base_q, fill_q - 1'b1);
    out_load  = 1'b0;
    ev        = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_TRACE) && te_q) begin
          pc_d              = in_pc;
          tgt_d             = in_tgt;
          ret_d             = (in_word == RET_WORD);
          scan_req.start    = 1'b1;
          scan_req.ret_mode = (in_word == RET_WORD);
          state_d           = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            key_d = scan_res.key;
            if (ret_q) begin
              scnt_d  = fill_q;
              state_d = ST_FIND;
            end else begin
              state_d = ST_CALL;
            end
          end else if (ret_q) begin
            // fall through to the call search
            ret_d             = 1'b0;
            scan_req.start    = 1'b1;
            scan_req.ret_mode = 1'b0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FIND: begin
        stk_raddr = phys(base_q, scnt_q - 1'b1);
        if (svld_q && (stk_rdata == key_q)) begin
          pos_d   = spos_q;
          state_d = ST_POP_RD;
        end else if ((scnt_q == '0) && !svld_q) begin
          state_d = ST_RET_ONE;
        end else if (scnt_q != '0) begin
          scnt_d = scnt_q - 1'b1;
          svld_d = 1'b1;
          spos_d = PA'(scnt_q - 1'b1);
        end
      end
      ST_RET_ONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          ev.kind   = EV_RETURN;
          ev.idx    = key_q;
          ev.depth  = depth_q - 1'b1;
          ev.pc     = pc_q;
          ev.target = '0;
          ev.last   = 1'b1;
          depth_d   = depth_q - 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_POP_RD: begin
        state_d = ST_POP_EMIT;
      end
      ST_POP_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ev.kind   = EV_RETURN;
          ev.idx    = stk_rdata;
          ev.depth  = depth_q - 1'b1;
          ev.pc     = pc_q;
          ev.target = '0;
          ev.last   = pop_last;
          depth_d   = depth_q - 1'b1;
          fill_d    = fill_q - 1'b1;
          state_d   = pop_last ? ST_IDLE : ST_POP_RD;
        end
      end
      ST_CALL: begin
        if (out_free) begin
          out_load  = 1'b1;
          ev.kind   = EV_CALL;
          ev.idx    = key_q;
          ev.depth  = depth_q;
          ev.pc     = pc_q;
          ev.target = tgt_q;
          ev.last   = 1'b1;
          depth_d   = depth_q + 1'b1;
          stk_we    = 1'b1;
          if (fill_q == FW'(STACK_DEPTH)) begin
            // drop the oldest entry
            base_d = (base_q == PA'(STACK_DEPTH - 1)) ? '0 : base_q + 1'b1;
          end else begin
            fill_d = fill_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      base_q    <= '0;
      depth_q   <= '0;
      svld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      base_q  <= base_d;
      depth_q <= depth_d;
      svld_q  <= svld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q   <= pc_d;
    tgt_q  <= tgt_d;
    ret_q  <= ret_d;
    key_q  <= key_d;
    pos_q  <= pos_d;
    scnt_q <= scnt_d;
    spos_q <= spos_d;
    if (out_load) begin
      out_q <= ev;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {7'b0, out_q.target, out_q.pc, out_q.depth, out_q.idx};

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(STACK_DEPTH))
    else $error("call stack fill exceeds depth");

  a_call_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALL && out_free) |=> depth_q == $past(depth_q) + 1'b1)
    else $error("call event did not advance depth");

  a_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_EMIT && out_free) |=> fill_q == $past(fill_q) - 1'b1)
    else $error("pop did not shrink stack");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_RD) |-> fill_q != '0)
    else $error("pop on empty stack");

endmodule
